>>> hdl/cle_pkg.sv
package cle_pkg;

    // field widths
    localparam int KEY_W      = 9;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 8;
    localparam int TAB_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // default line capacity and queue depth
    localparam int MAX_LINE_DEF = 255;
    localparam int QUEUE_DEPTH  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONSOLE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_RUN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_EDIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WEDIT    = 3'd5;

    // configuration reset values
    localparam logic             RST_CONSOLE_MODE = 1'b1;
    localparam logic [TAB_W-1:0] RST_TAB_WIDTH    = 4'd4;
    localparam logic [KEY_W-1:0] RST_KEY_RUN      = 9'd258;
    localparam logic [KEY_W-1:0] RST_KEY_LIST     = 9'd259;
    localparam logic [KEY_W-1:0] RST_KEY_EDIT     = 9'd260;
    localparam logic [KEY_W-1:0] RST_KEY_WEDIT    = 9'd261;

    // special key codes
    localparam logic [KEY_W-1:0] KEY_NULL     = 9'h000;
    localparam logic [KEY_W-1:0] KEY_BS       = 9'h008;
    localparam logic [KEY_W-1:0] KEY_TAB      = 9'h009;
    localparam logic [KEY_W-1:0] KEY_LF       = 9'h00A;
    localparam logic [KEY_W-1:0] KEY_CR       = 9'h00D;
    localparam logic [KEY_W-1:0] KEY_PRINT_LO = 9'h020;
    localparam logic [KEY_W-1:0] KEY_PRINT_HI = 9'h07E;

    // tab width limits
    localparam logic [TAB_W-1:0] TAB_MIN = 4'd1;
    localparam logic [TAB_W-1:0] TAB_MAX = 4'd8;

    // echo and store characters
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        OP_DONE,
        OP_WORD,
        OP_TAB,
        OP_BS,
        OP_CR,
        OP_CHAR,
        OP_OVF
    } t_op;

    typedef enum logic [1:0] {
        W_RUN,
        W_LIST,
        W_EDIT,
        W_WEDIT
    } t_word;

    typedef struct packed {
        logic             console_mode;
        logic [TAB_W-1:0] tab_width;
        logic [KEY_W-1:0] key_run;
        logic [KEY_W-1:0] key_list;
        logic [KEY_W-1:0] key_edit;
        logic [KEY_W-1:0] key_wedit;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic              con;
        t_word             word;
        logic [TAB_W-1:0]  tab_w;
        logic [CHAR_W-1:0] ch;
        logic              echo;
    } t_cmd;

    typedef struct packed {
        logic              store_valid;
        logic [CNT_W-1:0]  store_index;
        logic [CHAR_W-1:0] store_char;
        logic              echo_valid;
        logic [CHAR_W-1:0] echo_char;
        logic              line_done;
        logic [CNT_W-1:0]  line_length;
        logic              overflow;
        logic              last;
    } t_result;

    // number of characters in a function-key word
    function automatic logic [2:0] word_len(t_word w);
        logic [2:0] len;
        unique case (w)
            W_RUN:   len = 3'd3;
            W_LIST:  len = 3'd4;
            W_EDIT:  len = 3'd4;
            W_WEDIT: len = 3'd5;
            default: len = 3'd3;
        endcase
        return len;
    endfunction

    // character at a position of a function-key word
    function automatic logic [CHAR_W-1:0] word_char(t_word w, logic [2:0] pos);
        logic [39:0] s;
        unique case (w)
            W_RUN:   s = {"RUN", 16'h0000};
            W_LIST:  s = {"LIST", 8'h00};
            W_EDIT:  s = {"EDIT", 8'h00};
            W_WEDIT: s = "WEDIT";
            default: s = '0;
        endcase
        return s[39 - 8 * int'(pos) -: CHAR_W];
    endfunction

endpackage

>>> hdl/cle_in_if.sv
interface cle_in_if;
    logic                      valid;
    logic                      ready;
    logic [cle_pkg::KEY_W-1:0] key_code;
    logic                      end_of_input;

    modport source(output valid, output key_code, output end_of_input, input ready);
    modport sink(input valid, input key_code, input end_of_input, output ready);
endinterface

>>> hdl/cle_out_if.sv
interface cle_out_if;
    logic                       valid;
    logic                       ready;
    logic                       store_valid;
    logic [cle_pkg::CNT_W-1:0]  store_index;
    logic [cle_pkg::CHAR_W-1:0] store_char;
    logic                       echo_valid;
    logic [cle_pkg::CHAR_W-1:0] echo_char;
    logic                       line_done;
    logic [cle_pkg::CNT_W-1:0]  line_length;
    logic                       overflow;
    logic                       last;

    modport source(
        output valid, output store_valid, output store_index, output store_char,
        output echo_valid, output echo_char, output line_done, output line_length,
        output overflow, output last, input ready
    );
    modport sink(
        input valid, input store_valid, input store_index, input store_char,
        input echo_valid, input echo_char, input line_done, input line_length,
        input overflow, input last, output ready
    );
endinterface

>>> hdl/cle_cfg_if.sv
interface cle_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cle_pkg::CFG_IDX_W-1:0]  index;
    logic [cle_pkg::CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

>>> hdl/console_line_editor_core.sv
// Console line editor core.
// Key items enter on i_key_if (key_code, end_of_input); each item yields zero
// to eight result items on o_res_if, the final one flagged by last. Result
// items carry a line buffer write, an echo character, line completion with
// its length, or an overflow flag. Registers are written on i_cfg_if by
// index, which is always ready; write them only while no item is in flight.
// A key is classified on acceptance and parked in a two-entry command queue;
// the sequencer behind it emits one result per cycle into an output register
// while the receiver is ready. It pops a command in S_IDLE and emits its
// results in S_EMIT; a tab first runs a bitwise remainder unit (count modulo
// tab width) in S_MOD. Items without results end in S_IDLE.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; keys are still taken until the queue is full.
// Reset clears the character count, the queue and the output valid flag and
// loads the register defaults (console mode, tab width 4, function keys
// 258 to 261).
module console_line_editor_core #(
    parameter int MAX_LINE = cle_pkg::MAX_LINE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cle_in_if.sink    i_key_if,
    cle_out_if.source o_res_if,
    cle_cfg_if.sink   i_cfg_if
);

    cle_pkg::t_cfg cfg;
    cle_pkg::t_cmd push_cmd;
    cle_pkg::t_cmd pop_cmd;
    logic push, pop, full, empty;

    // configuration registers
    cle_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_if (i_cfg_if),
        .o_cfg    (cfg)
    );

    // key classification
    cle_front u_front (
        .i_key_if (i_key_if),
        .i_cfg    (cfg),
        .i_full   (full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // command queue
    cle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (pop_cmd)
    );

    // result sequencer and line count
    cle_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_cmd    (pop_cmd),
        .o_pop    (pop),
        .o_res_if (o_res_if)
    );

endmodule

>>> hdl/cle_cfg.sv
module cle_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cle_cfg_if.sink       i_cfg_if,
    output cle_pkg::t_cfg o_cfg
);

    cle_pkg::t_cfg r_cfg;

    // writes are always taken
    assign i_cfg_if.ready = 1'b1;
    assign o_cfg          = r_cfg;

    // register file, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.console_mode <= cle_pkg::RST_CONSOLE_MODE;
            r_cfg.tab_width    <= cle_pkg::RST_TAB_WIDTH;
            r_cfg.key_run      <= cle_pkg::RST_KEY_RUN;
            r_cfg.key_list     <= cle_pkg::RST_KEY_LIST;
            r_cfg.key_edit     <= cle_pkg::RST_KEY_EDIT;
            r_cfg.key_wedit    <= cle_pkg::RST_KEY_WEDIT;
        end else if (i_cfg_if.valid) begin
            unique case (i_cfg_if.index)
                cle_pkg::CFG_CONSOLE_MODE: r_cfg.console_mode <= i_cfg_if.data[0];
                cle_pkg::CFG_TAB_WIDTH:    r_cfg.tab_width <= i_cfg_if.data[cle_pkg::TAB_W-1:0];
                cle_pkg::CFG_KEY_RUN:      r_cfg.key_run   <= i_cfg_if.data[cle_pkg::KEY_W-1:0];
                cle_pkg::CFG_KEY_LIST:     r_cfg.key_list  <= i_cfg_if.data[cle_pkg::KEY_W-1:0];
                cle_pkg::CFG_KEY_EDIT:     r_cfg.key_edit  <= i_cfg_if.data[cle_pkg::KEY_W-1:0];
                cle_pkg::CFG_KEY_WEDIT:    r_cfg.key_wedit <= i_cfg_if.data[cle_pkg::KEY_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> hdl/cle_front.sv
module cle_front (
    cle_in_if.sink        i_key_if,
    input  cle_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output cle_pkg::t_cmd o_cmd
);

    logic drop;
    logic [cle_pkg::KEY_W-1:0] key;
    logic con;

    assign key = i_key_if.key_code;
    assign con = i_cfg.console_mode;

    // items are taken whenever the queue has room
    assign i_key_if.ready = !i_full;
    assign o_push         = i_key_if.valid && !i_full && !drop;

    // classify the key into a command for the back end
    always_comb begin
        drop        = 1'b0;
        o_cmd       = '0;
        o_cmd.op    = cle_pkg::OP_CHAR;
        o_cmd.con   = con;
        o_cmd.word  = cle_pkg::W_RUN;
        o_cmd.ch    = key[cle_pkg::CHAR_W-1:0];
        o_cmd.tab_w = i_cfg.tab_width;
        if (i_cfg.tab_width < cle_pkg::TAB_MIN) begin
            o_cmd.tab_w = cle_pkg::TAB_MIN;
        end else if (i_cfg.tab_width > cle_pkg::TAB_MAX) begin
            o_cmd.tab_w = cle_pkg::TAB_MAX;
        end
        o_cmd.echo = con && key >= cle_pkg::KEY_PRINT_LO && key <= cle_pkg::KEY_PRINT_HI;

        if (i_key_if.end_of_input) begin
            // end of input only ends a file line
            drop     = con;
            o_cmd.op = cle_pkg::OP_DONE;
        end else if (key == cle_pkg::KEY_NULL) begin
            drop = 1'b1;
        end else if (con && key == i_cfg.key_run) begin
            o_cmd.op   = cle_pkg::OP_WORD;
            o_cmd.word = cle_pkg::W_RUN;
        end else if (con && key == i_cfg.key_list) begin
            o_cmd.op   = cle_pkg::OP_WORD;
            o_cmd.word = cle_pkg::W_LIST;
        end else if (con && key == i_cfg.key_edit) begin
            o_cmd.op   = cle_pkg::OP_WORD;
            o_cmd.word = cle_pkg::W_EDIT;
        end else if (con && key == i_cfg.key_wedit) begin
            o_cmd.op   = cle_pkg::OP_WORD;
            o_cmd.word = cle_pkg::W_WEDIT;
        end else if (key == cle_pkg::KEY_TAB) begin
            o_cmd.op = cle_pkg::OP_TAB;
        end else if (key == cle_pkg::KEY_BS) begin
            o_cmd.op = cle_pkg::OP_BS;
        end else if (key == cle_pkg::KEY_LF) begin
            o_cmd.op = cle_pkg::OP_DONE;
        end else if (key == cle_pkg::KEY_CR) begin
            // carriage return is skipped in files
            drop     = !con;
            o_cmd.op = cle_pkg::OP_CR;
        end
    end

endmodule

>>> hdl/cle_queue.sv
module cle_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cle_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cle_pkg::t_cmd o_cmd
);

    localparam int Depth = cle_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;

    cle_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [PtrW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (PtrW + 1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // pointer advance with wrap
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // command storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> hdl/cle_back.sv
module cle_back #(
    parameter int MAX_LINE = cle_pkg::MAX_LINE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  cle_pkg::t_cmd i_cmd,
    output logic          o_pop,
    cle_out_if.source     o_res_if
);

    localparam int CntW = cle_pkg::CNT_W;
    localparam logic [CntW:0] MaxLine = (CntW + 1)'(MAX_LINE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    cle_pkg::t_cmd r_cmd, n_cmd;
    cle_pkg::t_result r_out, n_out;
    logic r_out_valid, n_out_valid;
    logic [CntW-1:0] r_count, n_count;
    logic [2:0] r_step, n_step;
    logic [3:0] r_total, n_total;
    logic [2:0] r_rem, n_rem;
    logic [2:0] r_bit, n_bit;

    cle_pkg::t_result res;
    logic slot_free;
    logic is_last;
    logic [2:0] wlen;
    logic [2:0] wlen_in;
    logic [3:0] rem_try;
    logic [3:0] tab_len;

    assign o_res_if.valid       = r_out_valid;
    assign o_res_if.store_valid = r_out.store_valid;
    assign o_res_if.store_index = r_out.store_index;
    assign o_res_if.store_char  = r_out.store_char;
    assign o_res_if.echo_valid  = r_out.echo_valid;
    assign o_res_if.echo_char   = r_out.echo_char;
    assign o_res_if.line_done   = r_out.line_done;
    assign o_res_if.line_length = r_out.line_length;
    assign o_res_if.overflow    = r_out.overflow;
    assign o_res_if.last        = r_out.last;

    assign slot_free = !r_out_valid || o_res_if.ready;
    assign is_last   = (({1'b0, r_step} + 4'd1) == r_total);
    assign wlen      = cle_pkg::word_len(r_cmd.word);
    assign wlen_in   = cle_pkg::word_len(i_cmd.word);

    // one restoring step of count modulo tab width
    always_comb begin
        rem_try = {r_rem, r_count[r_bit]};
        if (rem_try >= r_cmd.tab_w) begin
            rem_try = rem_try - r_cmd.tab_w;
        end
        tab_len = r_cmd.tab_w - rem_try;
    end

    // result of the current step
    always_comb begin
        res      = '0;
        res.last = is_last;
        case (r_cmd.op)
            cle_pkg::OP_DONE: begin
                res.line_done   = 1'b1;
                res.line_length = r_count;
            end
            cle_pkg::OP_OVF: begin
                res.overflow = 1'b1;
            end
            cle_pkg::OP_WORD: begin
                if (r_step < wlen) begin
                    res.store_valid = 1'b1;
                    res.store_index = r_count + {5'b0, r_step};
                    res.store_char  = cle_pkg::word_char(r_cmd.word, r_step);
                    res.echo_valid  = 1'b1;
                    res.echo_char   = cle_pkg::word_char(r_cmd.word, r_step);
                end else if (r_step == wlen) begin
                    res.echo_valid = 1'b1;
                    res.echo_char  = cle_pkg::CH_CR;
                end else begin
                    res.echo_valid  = 1'b1;
                    res.echo_char   = cle_pkg::CH_LF;
                    res.line_done   = 1'b1;
                    res.line_length = r_count + {5'b0, wlen};
                end
            end
            cle_pkg::OP_TAB: begin
                res.store_valid = 1'b1;
                res.store_index = r_count + {5'b0, r_step};
                res.store_char  = cle_pkg::CH_SPACE;
                res.echo_valid  = r_cmd.con;
                res.echo_char   = r_cmd.con ? cle_pkg::CH_SPACE : '0;
            end
            cle_pkg::OP_BS: begin
                res.echo_valid = 1'b1;
                res.echo_char  = (r_step == 3'd1) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
            end
            cle_pkg::OP_CR: begin
                res.echo_valid = 1'b1;
                if (r_step == 3'd0) begin
                    res.echo_char = cle_pkg::CH_CR;
                end else begin
                    res.echo_char   = cle_pkg::CH_LF;
                    res.line_done   = 1'b1;
                    res.line_length = r_count;
                end
            end
            cle_pkg::OP_CHAR: begin
                res.store_valid = 1'b1;
                res.store_index = r_count;
                res.store_char  = r_cmd.ch;
                res.echo_valid  = r_cmd.echo;
                res.echo_char   = r_cmd.echo ? r_cmd.ch : '0;
            end
            default: ;
        endcase
    end

    // the sequencer takes a command, sizes it and emits one result per cycle while the output slot is free
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res_if.ready;
        n_count     = r_count;
        n_step      = r_step;
        n_total     = r_total;
        n_rem       = r_rem;
        n_bit       = r_bit;
        o_pop       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_step  = '0;
                    n_total = 4'd1;
                    case (i_cmd.op)
                        cle_pkg::OP_DONE: n_state = S_EMIT;
                        cle_pkg::OP_CR: begin
                            n_total = 4'd2;
                            n_state = S_EMIT;
                        end
                        cle_pkg::OP_WORD: begin
                            if ({1'b0, r_count} + {6'b0, wlen_in} > MaxLine) begin
                                n_cmd.op = cle_pkg::OP_OVF;
                            end else begin
                                n_total = {1'b0, wlen_in} + 4'd2;
                            end
                            n_state = S_EMIT;
                        end
                        cle_pkg::OP_CHAR: begin
                            if ({1'b0, r_count} + 9'd1 > MaxLine) begin
                                n_cmd.op = cle_pkg::OP_OVF;
                            end
                            n_state = S_EMIT;
                        end
                        cle_pkg::OP_TAB: begin
                            n_rem   = '0;
                            n_bit   = 3'd7;
                            n_state = S_MOD;
                        end
                        cle_pkg::OP_BS: begin
                            if (r_count != '0) begin
                                if (i_cmd.con) begin
                                    n_total = 4'd3;
                                    n_state = S_EMIT;
                                end else begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                n_rem = rem_try[2:0];
                n_bit = r_bit - 1'b1;
                if (r_bit == 3'd0) begin
                    if ({1'b0, r_count} + {5'b0, tab_len} > MaxLine) begin
                        n_cmd.op = cle_pkg::OP_OVF;
                        n_total  = 4'd1;
                    end else begin
                        n_total = tab_len;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_step      = r_step + 1'b1;
                    if (is_last) begin
                        n_state = S_IDLE;
                        case (r_cmd.op)
                            cle_pkg::OP_TAB:  n_count = r_count + {4'b0, r_total};
                            cle_pkg::OP_BS:   n_count = r_count - 1'b1;
                            cle_pkg::OP_CHAR: n_count = r_count + 1'b1;
                            default:          n_count = '0;
                        endcase
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
        r_cmd   <= n_cmd;
        r_out   <= n_out;
        r_step  <= n_step;
        r_total <= n_total;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
    end

endmodule

>>> hdl/cle_checker.sv
module cle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_store_valid,
    input logic [7:0] i_store_index,
    input logic [7:0] i_store_char,
    input logic       i_echo_valid,
    input logic [7:0] i_echo_char,
    input logic       i_line_done,
    input logic [7:0] i_line_length,
    input logic       i_overflow,
    input logic       i_last
);

    // no result is shown right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_store_valid, i_store_index,
        i_store_char, i_echo_valid, i_echo_char, i_line_done, i_line_length,
        i_overflow, i_last}))
        else $error("stalled result changed");

    // unused store fields read as zero
    a_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_store_valid |-> i_store_index == 8'd0 && i_store_char == 8'd0)
        else $error("store fields set without store");

    // a finished line closes the item and writes nothing
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_line_done |-> i_last && !i_store_valid && !i_overflow)
        else $error("line done on a non-final result");

    // overflow is a lone result
    a_ovf_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_overflow |-> i_last && !i_store_valid && !i_echo_valid && !i_line_done)
        else $error("overflow result carries other fields");

endmodule

bind console_line_editor_core cle_checker u_cle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res_if.valid),
    .i_ready       (o_res_if.ready),
    .i_store_valid (o_res_if.store_valid),
    .i_store_index (o_res_if.store_index),
    .i_store_char  (o_res_if.store_char),
    .i_echo_valid  (o_res_if.echo_valid),
    .i_echo_char   (o_res_if.echo_char),
    .i_line_done   (o_res_if.line_done),
    .i_line_length (o_res_if.line_length),
    .i_overflow    (o_res_if.overflow),
    .i_last        (o_res_if.last)
);
